FILE: hw/rtl/lzjbd_pkg.sv
// ----------------------------------------------------------------------------
// lzjbd_pkg
// Types and constants shared by the LZJB block decompressor modules.
// ----------------------------------------------------------------------------
package lzjbd_pkg;

    localparam int unsigned HIST_DEPTH   = 1024;
    localparam int unsigned HIST_AW      = $clog2(HIST_DEPTH);
    localparam int unsigned LEN_FIELD_W  = 6;
    localparam int unsigned RUN_LEN_BASE = 3;
    localparam int unsigned OFF_BITS     = 16 - LEN_FIELD_W;
    localparam int unsigned LEN_W        = 7;
    localparam int unsigned PROD_W       = HIST_AW + 1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC_CTL = 2'd1;
    localparam logic [1:0] ST_TRUNC_MAT = 2'd2;
    localparam logic [1:0] ST_BAD_OFF   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic [1:0] byte_count;
        logic       run_last;
        logic [1:0] status;
        logic       block_done;
    } t_out_beat;

    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [HIST_AW-1:0] raddr;
    } t_ram_req;

    typedef enum logic [3:0] {
        S_IN    = 4'b0001,
        S_GET_A = 4'b0010,
        S_GET_B = 4'b0100,
        S_PUSH1 = 4'b1000
    } t_state;

endpackage

FILE: hw/rtl/lzjbd_ram.sv
// ----------------------------------------------------------------------------
// lzjbd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzjbd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/lzjbd_core.sv
// ----------------------------------------------------------------------------
// lzjbd_core
// Token decoder and match copy sequencer; drives the history RAM ports.
// ----------------------------------------------------------------------------
module lzjbd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  lzjbd_pkg::t_in_beat  i_in_data,
    output logic                 o_in_stall,
    input  logic                 i_res_ready,
    output logic                 o_res_push,
    output lzjbd_pkg::t_out_beat o_res_data,
    output lzjbd_pkg::t_ram_req  o_ram_req,
    input  logic [7:0]           i_ram_q
);

    lzjbd_pkg::t_state r_state, n_state;

    logic [lzjbd_pkg::HIST_AW-1:0] r_wp, n_wp;
    logic [lzjbd_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic [7:0]                    r_ctl, n_ctl;
    logic [2:0]                    r_bitpos, n_bitpos;
    logic                          r_pending, n_pending;
    logic                          r_discard, n_discard;
    logic                          r_fresh, n_fresh;
    logic [lzjbd_pkg::LEN_W-1:0]   r_len, n_len;
    logic                          r_end, n_end;

    logic [7:0]                    r_hi, n_hi;
    logic [lzjbd_pkg::HIST_AW-1:0] r_src, n_src;
    logic                          r_off_one, n_off_one;
    logic [7:0]                    r_last, n_last;
    logic [7:0]                    r_b0, n_b0;

    logic                               accept;
    logic                               restart;
    logic                               put;
    logic [7:0]                         put_byte;
    logic [lzjbd_pkg::OFF_BITS-1:0]     off;
    logic [2:0]                         bp_next;
    logic [7:0]                         copy_byte;

    assign accept     = i_in_valid && (r_state == lzjbd_pkg::S_IN) && i_res_ready;
    assign o_in_stall = !((r_state == lzjbd_pkg::S_IN) && i_res_ready);
    assign off        = {r_hi[1:0], i_in_data.data_byte};
    assign bp_next    = r_fresh ? 3'd0 : r_bitpos + 3'd1;
    // offset one always repeats the byte written last
    assign copy_byte  = r_off_one ? r_last : i_ram_q;

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_prod    = r_prod;
        n_ctl     = r_ctl;
        n_bitpos  = r_bitpos;
        n_pending = r_pending;
        n_discard = r_discard;
        n_fresh   = r_fresh;
        n_len     = r_len;
        n_end     = r_end;
        n_hi      = r_hi;
        n_src     = r_src;
        n_off_one = r_off_one;
        n_last    = r_last;
        n_b0      = r_b0;
        restart   = 1'b0;
        put       = 1'b0;
        put_byte  = i_in_data.data_byte;
        o_res_push = 1'b0;
        o_res_data = '0;
        o_ram_req  = '0;

        unique case (r_state)
            lzjbd_pkg::S_IN: begin
                if (accept) begin
                    if (r_discard) begin
                        restart = i_in_data.block_end;
                    end else if (r_pending) begin
                        n_pending = 1'b0;
                        if (off == '0 || {1'b0, off} > r_prod) begin
                            o_res_push            = 1'b1;
                            o_res_data.run_last   = 1'b1;
                            o_res_data.status     = lzjbd_pkg::ST_BAD_OFF;
                            o_res_data.block_done = i_in_data.block_end;
                            if (i_in_data.block_end) begin
                                restart = 1'b1;
                            end else begin
                                n_discard = 1'b1;
                            end
                        end else begin
                            n_src     = r_wp - off;
                            n_len     = lzjbd_pkg::LEN_W'(r_hi[7:2])
                                        + lzjbd_pkg::LEN_W'(lzjbd_pkg::RUN_LEN_BASE);
                            n_off_one = (off == lzjbd_pkg::OFF_BITS'(1));
                            n_end     = i_in_data.block_end;
                            o_ram_req.re    = 1'b1;
                            o_ram_req.raddr = r_wp - off;
                            n_state   = lzjbd_pkg::S_GET_A;
                        end
                    end else if (!r_fresh && r_bitpos == 3'd7) begin
                        n_ctl   = i_in_data.data_byte;
                        n_fresh = 1'b1;
                        if (i_in_data.block_end) begin
                            o_res_push            = 1'b1;
                            o_res_data.run_last   = 1'b1;
                            o_res_data.status     = lzjbd_pkg::ST_TRUNC_CTL;
                            o_res_data.block_done = 1'b1;
                            restart               = 1'b1;
                        end
                    end else begin
                        n_bitpos = bp_next;
                        n_fresh  = 1'b0;
                        if (r_ctl[bp_next]) begin
                            if (i_in_data.block_end) begin
                                o_res_push            = 1'b1;
                                o_res_data.run_last   = 1'b1;
                                o_res_data.status     = lzjbd_pkg::ST_TRUNC_MAT;
                                o_res_data.block_done = 1'b1;
                                restart               = 1'b1;
                            end else begin
                                n_hi      = i_in_data.data_byte;
                                n_pending = 1'b1;
                            end
                        end else begin
                            put                   = 1'b1;
                            o_res_push            = 1'b1;
                            o_res_data.byte_first = i_in_data.data_byte;
                            o_res_data.byte_count = 2'd1;
                            o_res_data.run_last   = 1'b1;
                            o_res_data.status     = lzjbd_pkg::ST_OK;
                            o_res_data.block_done = i_in_data.block_end;
                            restart               = i_in_data.block_end;
                        end
                    end
                end
            end

            lzjbd_pkg::S_GET_A: begin
                put      = 1'b1;
                put_byte = copy_byte;
                n_b0     = copy_byte;
                n_src    = r_src + lzjbd_pkg::HIST_AW'(1);
                n_len    = r_len - lzjbd_pkg::LEN_W'(1);
                if (r_len == lzjbd_pkg::LEN_W'(1)) begin
                    n_state = lzjbd_pkg::S_PUSH1;
                end else begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = r_src + lzjbd_pkg::HIST_AW'(1);
                    n_state         = lzjbd_pkg::S_GET_B;
                end
            end

            lzjbd_pkg::S_GET_B: begin
                // hold the RAM output until the result slot frees up
                if (i_res_ready) begin
                    put                    = 1'b1;
                    put_byte               = copy_byte;
                    n_src                  = r_src + lzjbd_pkg::HIST_AW'(1);
                    n_len                  = r_len - lzjbd_pkg::LEN_W'(1);
                    o_res_push             = 1'b1;
                    o_res_data.byte_first  = r_b0;
                    o_res_data.byte_second = copy_byte;
                    o_res_data.byte_count  = 2'd2;
                    o_res_data.status      = lzjbd_pkg::ST_OK;
                    if (r_len == lzjbd_pkg::LEN_W'(1)) begin
                        o_res_data.run_last   = 1'b1;
                        o_res_data.block_done = r_end;
                        restart               = r_end;
                        n_state               = lzjbd_pkg::S_IN;
                    end else begin
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = r_src + lzjbd_pkg::HIST_AW'(1);
                        n_state         = lzjbd_pkg::S_GET_A;
                    end
                end
            end

            lzjbd_pkg::S_PUSH1: begin
                if (i_res_ready) begin
                    o_res_push            = 1'b1;
                    o_res_data.byte_first = r_b0;
                    o_res_data.byte_count = 2'd1;
                    o_res_data.run_last   = 1'b1;
                    o_res_data.status     = lzjbd_pkg::ST_OK;
                    o_res_data.block_done = r_end;
                    restart               = r_end;
                    n_state               = lzjbd_pkg::S_IN;
                end
            end

            default: begin
                n_state = lzjbd_pkg::S_IN;
            end
        endcase

        if (put) begin
            o_ram_req.we    = 1'b1;
            o_ram_req.waddr = r_wp;
            o_ram_req.wdata = put_byte;
            n_wp            = r_wp + lzjbd_pkg::HIST_AW'(1);
            n_last          = put_byte;
            if (r_prod < lzjbd_pkg::PROD_W'(lzjbd_pkg::HIST_DEPTH)) begin
                n_prod = r_prod + lzjbd_pkg::PROD_W'(1);
            end
        end

        if (restart) begin
            n_wp      = '0;
            n_prod    = '0;
            n_ctl     = '0;
            n_bitpos  = 3'd7;
            n_pending = 1'b0;
            n_hi      = '0;
            n_discard = 1'b0;
            n_fresh   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lzjbd_pkg::S_IN;
            r_wp      <= '0;
            r_prod    <= '0;
            r_ctl     <= '0;
            r_bitpos  <= 3'd7;
            r_pending <= 1'b0;
            r_discard <= 1'b0;
            r_fresh   <= 1'b0;
            r_len     <= '0;
            r_end     <= 1'b0;
            r_hi      <= '0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_prod    <= n_prod;
            r_ctl     <= n_ctl;
            r_bitpos  <= n_bitpos;
            r_pending <= n_pending;
            r_discard <= n_discard;
            r_fresh   <= n_fresh;
            r_len     <= n_len;
            r_end     <= n_end;
            r_hi      <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_off_one <= n_off_one;
        r_last    <= n_last;
        r_b0      <= n_b0;
    end

endmodule

FILE: hw/rtl/lzjb_block_decompressor_top.sv
// ----------------------------------------------------------------------------
// lzjb_block_decompressor_top
// LZJB block decompressor with a 1024-byte history RAM and an output register.
// ----------------------------------------------------------------------------
// Input channel: one compressed byte per beat with a block-end mark, taken
// when i_in_valid is high and o_in_stall is low. Output channel: results of
// one or two decompressed bytes, or an error status, each held in an output
// register until taken (o_out_valid high, i_out_stall low).
// Control bytes, literals and first match bytes are each consumed in state S_IN;
// a result appears in the output register in the cycle after the beat that causes it.
// A match of L bytes (3 to 66) is copied from the history RAM one byte per
// cycle, while the receiver does not stall, through its single registered read
// port; the block issues two-byte results, with a final one-byte result when L
// is odd. Input is not taken during a copy.
// Reset clears the decoder state; the history RAM is not cleared, as offsets
// are checked against the bytes produced in the current block.
// When the receiver stalls, the pending result is held, the copy pauses
// and the input is stalled.
// ----------------------------------------------------------------------------
module lzjb_block_decompressor_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  lzjbd_pkg::t_in_beat  i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output lzjbd_pkg::t_out_beat o_out_data,
    input  logic                 i_out_stall
);

    logic                 res_ready;
    logic                 res_push;
    lzjbd_pkg::t_out_beat res_data;
    lzjbd_pkg::t_ram_req  ram_req;
    logic [7:0]           ram_q;

    logic                 r_out_valid, n_out_valid;
    lzjbd_pkg::t_out_beat r_out_data;

    assign res_ready = !r_out_valid || !i_out_stall;

    lzjbd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_res_ready (res_ready),
        .o_res_push  (res_push),
        .o_res_data  (res_data),
        .o_ram_req   (ram_req),
        .i_ram_q     (ram_q)
    );

    lzjbd_ram #(
        .WIDTH (8),
        .DEPTH (lzjbd_pkg::HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (res_push) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_out_data <= res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
